[rtl/core/alsdp_pkg.sv]
// Shared types, constants and helpers for the two-line assembly-line scheduler.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package alsdp_pkg;

    localparam int COST_W    = 16;
    localparam int TIME_W    = 24;
    localparam int STATION_W = 6;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTRY_LINE0 = 2'd0,
        REG_ENTRY_LINE1 = 2'd1,
        REG_EXIT_LINE0  = 2'd2,
        REG_EXIT_LINE1  = 2'd3
    } cfg_reg_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TRACE
    } trace_state_t;

    // What one lane found for its line at the current station
    typedef struct packed {
        logic [TIME_W-1:0] best;
        logic              from_other;
    } lane_result_t;

    // Best exit over both lines
    typedef struct packed {
        logic [TIME_W-1:0] total;
        logic              line;
    } exit_choice_t;

    // Add two times and clamp at the largest 24-bit value
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

[rtl/core/alsdp_lane.sv]
// One line's step of the scheduling recurrence: stay on this line or move over.
// Depends on alsdp_pkg for sat_add and lane_result_t.
`timescale 1ns / 1ps

module alsdp_lane
    import alsdp_pkg::*;
(
    input  logic [TIME_W-1:0] own_best,
    input  logic [TIME_W-1:0] other_best,
    input  logic [COST_W-1:0] switch_cost,
    input  logic [COST_W-1:0] station_cost,
    output lane_result_t      result
);

    logic [TIME_W-1:0] stay_time;
    logic [TIME_W-1:0] move_time;

    // Form both candidate times
    always_comb
    begin
        stay_time = sat_add(own_best, TIME_W'(station_cost));
        move_time = sat_add(sat_add(other_best, TIME_W'(switch_cost)),
                            TIME_W'(station_cost));
    end

    // Pick the cheaper one; a tie stays on this line
    always_comb
    begin
        result.from_other = (stay_time > move_time);
        result.best       = result.from_other ? move_time : stay_time;
    end

endmodule

[rtl/core/alsdp_merge.sv]
// Merge stage: packs both lanes' choices into predecessor bits and picks the exit.
// Depends on alsdp_pkg for lane_result_t, exit_choice_t and sat_add.
`timescale 1ns / 1ps

module alsdp_merge
    import alsdp_pkg::*;
(
    input  lane_result_t      lane0,
    input  lane_result_t      lane1,
    input  logic [TIME_W-1:0] best_line0,
    input  logic [TIME_W-1:0] best_line1,
    input  logic [COST_W-1:0] exit_line0,
    input  logic [COST_W-1:0] exit_line1,
    output logic [1:0]        pred_bits,
    output exit_choice_t      exit_choice
);

    logic [TIME_W-1:0] end_line0;
    logic [TIME_W-1:0] end_line1;

    // Store the predecessor line of each line: bit 0 for line 0, bit 1 for line 1
    always_comb
    begin
        pred_bits[0] = lane0.from_other;
        pred_bits[1] = ~lane1.from_other;
    end

    // Add exit costs and choose; a tie picks line 0
    always_comb
    begin
        end_line0 = sat_add(best_line0, TIME_W'(exit_line0));
        end_line1 = sat_add(best_line1, TIME_W'(exit_line1));
        if (end_line0 <= end_line1)
        begin
            exit_choice.total = end_line0;
            exit_choice.line  = 1'b0;
        end
        else
        begin
            exit_choice.total = end_line1;
            exit_choice.line  = 1'b1;
        end
    end

endmodule

[rtl/core/assembly_line_schedule_dp_core.sv]
// Top level of the two-line assembly-line scheduler; uses alsdp_lane, alsdp_merge
// and alsdp_pkg. Station items are taken one per cycle while the block is idle.
// After the last station, the load state fetches the exit choice; then the path
// leaves one result per cycle while result_ready allows, last station first,
// through the result register; input is held off until the last one is loaded.
// Reset clears control, configuration and recurrence registers; the result
// payload and the predecessor memory are not cleared.
`timescale 1ns / 1ps

module assembly_line_schedule_dp_core
    import alsdp_pkg::*;
#(
    parameter int MAX_STATIONS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COST_W-1:0]    cfg_data,

    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic                 first_station,
    input  logic                 last_station,
    input  logic [COST_W-1:0]    cost_line0,
    input  logic [COST_W-1:0]    cost_line1,
    input  logic [COST_W-1:0]    switch_from_line0,
    input  logic [COST_W-1:0]    switch_from_line1,

    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [STATION_W-1:0] station_index,
    output logic                 chosen_line,
    output logic [TIME_W-1:0]    total_time,
    output logic                 capacity_exceeded,
    output logic                 path_end
);

    localparam int AW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
    localparam int CW = $clog2(MAX_STATIONS + 1);

    // Configuration registers
    logic [COST_W-1:0] entry0_reg, entry1_reg, exit0_reg, exit1_reg;

    // Recurrence state
    logic [TIME_W-1:0] best0_reg, best0_next;
    logic [TIME_W-1:0] best1_reg, best1_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;

    // Traceback state
    trace_state_t      state_reg, state_next;
    logic [AW-1:0]     trace_j_reg, trace_j_next;
    logic              trace_line_reg, trace_line_next;
    logic [TIME_W-1:0] total_reg, total_next;

    // Result register
    logic                 out_valid_reg, out_valid_next;
    logic [STATION_W-1:0] out_index_reg, out_index_next;
    logic                 out_line_reg, out_line_next;
    logic [TIME_W-1:0]    out_total_reg, out_total_next;
    logic                 out_ovf_reg, out_ovf_next;
    logic                 out_end_reg, out_end_next;

    // Predecessor memory
    logic [1:0]    pred_mem [MAX_STATIONS];
    logic [1:0]    rdata_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_data;

    // Datapath wires
    lane_result_t  lane0_res, lane1_res;
    logic [1:0]    pred_bits;
    exit_choice_t  exit_choice;
    logic          item_xfer;
    logic          start_run;
    logic          full;
    logic          emit;

    assign cfg_ready  = 1'b1;
    assign item_ready = (state_reg == ST_IDLE);
    assign item_xfer  = item_valid && item_ready;
    assign start_run  = first_station || (count_reg == '0);
    assign full       = (count_reg >= CW'(MAX_STATIONS));
    assign emit       = (state_reg == ST_TRACE) && (!out_valid_reg || result_ready);

    // Line 0 lane: stays on line 0 or arrives from line 1
    alsdp_lane u_lane0 (
        .own_best     (best0_reg),
        .other_best   (best1_reg),
        .switch_cost  (switch_from_line1),
        .station_cost (cost_line0),
        .result       (lane0_res)
    );

    // Line 1 lane: stays on line 1 or arrives from line 0
    alsdp_lane u_lane1 (
        .own_best     (best1_reg),
        .other_best   (best0_reg),
        .switch_cost  (switch_from_line0),
        .station_cost (cost_line1),
        .result       (lane1_res)
    );

    alsdp_merge u_merge (
        .lane0       (lane0_res),
        .lane1       (lane1_res),
        .best_line0  (best0_reg),
        .best_line1  (best1_reg),
        .exit_line0  (exit0_reg),
        .exit_line1  (exit1_reg),
        .pred_bits   (pred_bits),
        .exit_choice (exit_choice)
    );

    // Next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer && last_station)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_TRACE;
            end
            ST_TRACE:
            begin
                if (emit && (trace_j_reg == '0))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Station update, memory write and traceback outputs
    always_comb
    begin
        best0_next      = best0_reg;
        best1_next      = best1_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        trace_j_next    = trace_j_reg;
        trace_line_next = trace_line_reg;
        total_next      = total_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_addr         = trace_j_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_index_next  = out_index_reg;
        out_line_next   = out_line_reg;
        out_total_next  = out_total_reg;
        out_ovf_next    = out_ovf_reg;
        out_end_next    = out_end_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    priority if (start_run)
                    begin
                        ovf_next   = 1'b0;
                        best0_next = sat_add(TIME_W'(entry0_reg), TIME_W'(cost_line0));
                        best1_next = sat_add(TIME_W'(entry1_reg), TIME_W'(cost_line1));
                        count_next = CW'(1);
                        wr_en      = 1'b1;
                    end
                    else if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        best0_next = lane0_res.best;
                        best1_next = lane1_res.best;
                        count_next = count_reg + CW'(1);
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[AW-1:0];
                        wr_data    = pred_bits;
                    end
                    // Close the run: walk back from the last kept station
                    if (last_station)
                    begin
                        trace_j_next = AW'(count_next - CW'(1));
                        count_next   = '0;
                    end
                end
            end
            ST_LOAD:
            begin
                total_next      = exit_choice.total;
                trace_line_next = exit_choice.line;
            end
            ST_TRACE:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = STATION_W'(trace_j_reg);
                    out_line_next  = trace_line_reg;
                    out_total_next = total_reg;
                    out_ovf_next   = ovf_reg;
                    out_end_next   = (trace_j_reg == '0);
                    if (trace_j_reg != '0)
                    begin
                        trace_j_next    = trace_j_reg - AW'(1);
                        trace_line_next = rdata_reg[trace_line_reg];
                        rd_addr         = trace_j_reg - AW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry0_reg <= '0;
            entry1_reg <= '0;
            exit0_reg  <= '0;
            exit1_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ENTRY_LINE0: entry0_reg <= cfg_data;
                REG_ENTRY_LINE1: entry1_reg <= cfg_data;
                REG_EXIT_LINE0:  exit0_reg  <= cfg_data;
                REG_EXIT_LINE1:  exit1_reg  <= cfg_data;
            endcase
        end
    end

    // Advance control and recurrence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            best0_reg      <= '0;
            best1_reg      <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            trace_j_reg    <= '0;
            trace_line_reg <= 1'b0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            best0_reg      <= best0_next;
            best1_reg      <= best1_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            trace_j_reg    <= trace_j_next;
            trace_line_reg <= trace_line_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        out_index_reg <= out_index_next;
        out_line_reg  <= out_line_next;
        out_total_reg <= out_total_next;
        out_ovf_reg   <= out_ovf_next;
        out_end_reg   <= out_end_next;
    end

    // Predecessor memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pred_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= pred_mem[rd_addr];
    end

    assign result_valid      = out_valid_reg;
    assign station_index     = out_index_reg;
    assign chosen_line       = out_line_reg;
    assign total_time        = out_total_reg;
    assign capacity_exceeded = out_ovf_reg;
    assign path_end          = out_end_reg;

endmodule
